>>> hdl/dpf_pkg.sv
package dpf_pkg;

   // Command codes carried by the kind field of a request.
   typedef enum logic [2:0] {
      KIND_START   = 3'd0,
      KIND_RAW     = 3'd1,
      KIND_ESCAPED = 3'd2,
      KIND_HEX8    = 3'd3,
      KIND_HEX16   = 3'd4,
      KIND_HEX32   = 3'd5,
      KIND_UNAVAIL = 3'd6,
      KIND_END     = 3'd7
   } kind_type;

   // Protocol characters.
   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_BRACE   = 8'h7d;
   localparam logic [7:0] CH_STAR    = 8'h2a;
   localparam logic [7:0] ESC_XOR    = 8'h20;
   localparam logic [3:0] NIBBLE     = 4'hf;
   localparam logic [7:0] CH_UNAVAIL = 8'h78;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_UPPER_A = 8'h41;

   // Default depth of the command queue between front and back.
   localparam int QUEUE_DEPTH = 4;

   // A classified command: what the back end needs to emit its characters.
   typedef struct packed {
      kind_type    kind;
      logic        escape;     // escaped byte needs a brace prefix
      logic [2:0]  last_step;  // index of the final character
      logic [31:0] data;       // hex digits left aligned, bytes in bits 7..0
   } cmd_type;

   // ASCII hex digit for one nibble.
   function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
      logic [7:0] value;
      value = {4'b0000, nib & NIBBLE};
      if (value < 8'd10) begin
         return CH_ZERO + value;
      end
      return (upper ? CH_UPPER_A : CH_LOWER_A) + (value - 8'd10);
   endfunction

endpackage

>>> hdl/dpf_front.sv
module dpf_front (
   input  logic [2:0]      req_kind,
   input  logic [31:0]     req_data_value,
   output dpf_pkg::cmd_type cmd
);

   logic [7:0] byte_value;
   logic       special;

   assign byte_value = req_data_value[7:0];

   // Bytes that must be escaped inside a packet.
   assign special = (byte_value == dpf_pkg::CH_HASH) || (byte_value == dpf_pkg::CH_DOLLAR) ||
                    (byte_value == dpf_pkg::CH_BRACE) || (byte_value == dpf_pkg::CH_STAR);

   // Classify the request: character count, escape need and digit alignment.
   always_comb begin
      cmd.kind      = dpf_pkg::kind_type'(req_kind);
      cmd.escape    = 1'b0;
      cmd.last_step = 3'd0;
      cmd.data      = req_data_value;
      case (dpf_pkg::kind_type'(req_kind))
         dpf_pkg::KIND_START: begin
            cmd.last_step = 3'd0;
         end
         dpf_pkg::KIND_RAW: begin
            cmd.last_step = 3'd0;
         end
         dpf_pkg::KIND_ESCAPED: begin
            cmd.escape    = special;
            cmd.last_step = special ? 3'd1 : 3'd0;
         end
         dpf_pkg::KIND_HEX8: begin
            cmd.last_step = 3'd1;
            cmd.data      = {req_data_value[7:0], 24'd0};
         end
         dpf_pkg::KIND_HEX16: begin
            cmd.last_step = 3'd3;
            cmd.data      = {req_data_value[15:0], 16'd0};
         end
         dpf_pkg::KIND_HEX32: begin
            cmd.last_step = 3'd7;
         end
         dpf_pkg::KIND_UNAVAIL: begin
            cmd.last_step = 3'd7;
         end
         dpf_pkg::KIND_END: begin
            cmd.last_step = 3'd2;
         end
         default: begin
            cmd.last_step = 3'd0;
         end
      endcase
   end

endmodule

>>> hdl/dpf_queue.sv
module dpf_queue #(
   parameter int Depth = dpf_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dpf_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output dpf_pkg::cmd_type pop_data,
   output logic             empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   dpf_pkg::cmd_type entry_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CntW'(Depth));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/dpf_back.sv
module dpf_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   input  logic             csr_hex_uppercase,
   input  dpf_pkg::cmd_type q_data,
   input  logic             q_empty,
   output logic             q_pop,
   output logic [7:0]       rsp_out_char,
   output logic             rsp_last,
   output logic [15:0]      rsp_packet_length,
   output logic             rsp_empty,
   input  logic             rsp_pop
);

   logic             upper_ff;
   logic [7:0]       sum_ff, sum_in;
   logic [15:0]      count_ff, count_in;
   logic             busy_ff;
   dpf_pkg::cmd_type cmd_ff;
   logic [2:0]       step_ff;
   logic [31:0]      shift_ff, shift_in;
   logic             out_valid_ff;
   logic [7:0]       out_char_ff;
   logic             out_last_ff;
   logic [15:0]      out_length_ff;
   logic             out_ready;
   logic             adv;
   logic             final_step;
   logic [7:0]       ch;
   logic             counted;
   logic             clear;
   logic [7:0]       hex_digit;

   assign out_ready  = !out_valid_ff || rsp_pop;
   assign adv        = busy_ff && out_ready;
   assign final_step = (step_ff == cmd_ff.last_step);
   assign q_pop      = !q_empty && (!busy_ff || (adv && final_step));
   assign hex_digit  = dpf_pkg::hex_char(shift_ff[31:28], upper_ff);

   // Character for the current step of the active command.
   always_comb begin
      ch       = hex_digit;
      counted  = 1'b1;
      clear    = 1'b0;
      shift_in = {shift_ff[27:0], 4'd0};
      case (cmd_ff.kind)
         dpf_pkg::KIND_START: begin
            ch      = dpf_pkg::CH_DOLLAR;
            counted = 1'b0;
            clear   = 1'b1;
         end
         dpf_pkg::KIND_RAW: begin
            ch = cmd_ff.data[7:0];
         end
         dpf_pkg::KIND_ESCAPED: begin
            if (cmd_ff.escape && (step_ff == 3'd0)) begin
               ch = dpf_pkg::CH_BRACE;
            end else if (cmd_ff.escape) begin
               ch = cmd_ff.data[7:0] ^ dpf_pkg::ESC_XOR;
            end else begin
               ch = cmd_ff.data[7:0];
            end
         end
         dpf_pkg::KIND_HEX8, dpf_pkg::KIND_HEX16, dpf_pkg::KIND_HEX32: begin
            ch = hex_digit;
         end
         dpf_pkg::KIND_UNAVAIL: begin
            ch = dpf_pkg::CH_UNAVAIL;
         end
         dpf_pkg::KIND_END: begin
            // The checksum digits come from the sum as it stands at the '#'.
            if (step_ff == 3'd0) begin
               ch       = dpf_pkg::CH_HASH;
               counted  = 1'b0;
               shift_in = {sum_ff, 24'd0};
            end
         end
         default: begin
            ch = hex_digit;
         end
      endcase
   end

   // Checksum and payload length after this character.
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (clear) begin
         sum_in   = '0;
         count_in = '0;
      end else if (counted) begin
         sum_in   = sum_ff + ch;
         count_in = count_ff + 16'd1;
      end
   end

   // Control state: configuration, checksum, length and step sequencing.
   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff     <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            upper_ff <= csr_hex_uppercase;
         end
         if (adv) begin
            sum_ff   <= sum_in;
            count_ff <= count_in;
         end
         if (q_pop) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (adv && final_step) begin
            busy_ff <= 1'b0;
         end else if (adv) begin
            step_ff <= step_ff + 3'd1;
         end
         if (adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Command and output payload registers.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff   <= q_data;
         shift_ff <= q_data.data;
      end else if (adv) begin
         shift_ff <= shift_in;
      end
      if (adv) begin
         out_char_ff   <= ch;
         out_last_ff   <= final_step;
         out_length_ff <= count_in;
      end
   end

   assign rsp_out_char      = out_char_ff;
   assign rsp_last          = out_last_ff;
   assign rsp_packet_length = out_length_ff;
   assign rsp_empty         = !out_valid_ff;

   // The step index never runs past the final character of a command.
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (step_ff <= cmd_ff.last_step))
      else $error("step index beyond last character");

   // A new command is only taken when the active one is done or absent.
   a_pop_when_free: assert property (@(posedge clock) disable iff (reset)
      (q_pop && busy_ff) |-> (adv && final_step))
      else $error("command taken while previous one still active");

   // A start character resets the length reported with it.
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (adv && (cmd_ff.kind == dpf_pkg::KIND_START)) |=>
      (out_valid_ff && (out_length_ff == 16'd0) && (sum_ff == 8'd0)))
      else $error("start did not clear checksum and length");

   // The final character of a command carries the last flag.
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      (adv && final_step) |=> (out_valid_ff && out_last_ff))
      else $error("last flag missing on final character");

endmodule

>>> hdl/debug_packet_framer.sv
// Channel   Ports                                            Direction
// request   req_push, req_full, req_kind, req_data_value     in
// response  rsp_pop, rsp_empty, rsp_out_char, rsp_last,
//           rsp_packet_length                                 out
// csr       csr_valid, csr_ready, csr_hex_uppercase          in
//
// The back end emits one character per cycle while the output register is free, so
// an item is 1 to 8 characters (start and raw 1, escaped 1 or 2, hex 2/4/8, unavailable 8, end 3).
// Requests enter the command queue at one per cycle until it is full.
// Synchronous reset clears the queue, checksum, length and hex_uppercase.
// A low rsp_pop holds the output register, which stalls the back end and
// lets the queue fill until req_full rises.
module debug_packet_framer #(
   parameter int QueueDepth = dpf_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_kind,
   input  logic [31:0] req_data_value,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last,
   output logic [15:0] rsp_packet_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_hex_uppercase
);

   dpf_pkg::cmd_type front_cmd;
   dpf_pkg::cmd_type q_data;
   logic             q_empty;
   logic             q_pop;
   logic             q_full;

   assign req_full  = q_full;
   assign csr_ready = 1'b1;

   dpf_front u_front (
      .req_kind      (req_kind),
      .req_data_value(req_data_value),
      .cmd           (front_cmd)
   );

   dpf_queue #(
      .Depth(QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .push_data(front_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (q_data),
      .empty    (q_empty)
   );

   dpf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_hex_uppercase(csr_hex_uppercase),
      .q_data           (q_data),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .rsp_out_char     (rsp_out_char),
      .rsp_last         (rsp_last),
      .rsp_packet_length(rsp_packet_length),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop)
   );

endmodule
